>>> src/taabb_pkg.sv
// ----------------------------------------------------------------------------
// taabb_pkg: shared types and constants for the transformed box overlap block
// Coordinate and coefficient formats, channel words and box records.
// ----------------------------------------------------------------------------
package taabb_pkg;

  localparam int COORD_WIDTH = 16;             // signed Q8.8 coordinates
  localparam int COEF_WIDTH  = 16;             // signed Q4.12 coefficients
  localparam int TRANS_WIDTH = 16;             // signed Q8.8 translation lanes
  localparam int LANES       = 3;
  localparam int PACK_WIDTH  = LANES * COEF_WIDTH;
  localparam int FRAC_SHIFT  = 12;             // 20 fraction bits down to 8
  localparam int PROD_WIDTH  = COORD_WIDTH + COEF_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 2; // three products plus translation
  localparam int QUOT_WIDTH  = SUM_WIDTH - FRAC_SHIFT;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_TEST  = 1'b1
  } opcode_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  typedef struct packed {
    vec3_t lo;
    vec3_t hi;
  } box_t;

  typedef struct packed {
    opcode_t                opcode;
    coord_t                 local_min_x;
    coord_t                 local_min_y;
    coord_t                 local_min_z;
    coord_t                 local_max_x;
    coord_t                 local_max_y;
    coord_t                 local_max_z;
    logic [PACK_WIDTH-1:0]  row_x_coeffs;
    logic [PACK_WIDTH-1:0]  row_y_coeffs;
    logic [PACK_WIDTH-1:0]  row_z_coeffs;
    logic [PACK_WIDTH-1:0]  translation;
  } in_word_t;

  typedef struct packed {
    coord_t world_min_x;
    coord_t world_min_y;
    coord_t world_min_z;
    coord_t world_max_x;
    coord_t world_max_y;
    coord_t world_max_z;
    logic   overlap;
  } out_word_t;

endpackage

>>> src/taabb_if.sv
// ----------------------------------------------------------------------------
// taabb_if: valid/ready channels of the transformed box overlap block
// One interface for the item words in, one for the result words out.
// ----------------------------------------------------------------------------
interface taabb_in_if import taabb_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface taabb_out_if import taabb_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/taabb_axis.sv
// ----------------------------------------------------------------------------
// taabb_axis: world bounds along one axis
// Three coefficient products per corner bound, translation, rounding and
// saturation to the coordinate range.
// ----------------------------------------------------------------------------
module taabb_axis import taabb_pkg::*; (
  input  vec3_t                  lo,
  input  vec3_t                  hi,
  input  logic [PACK_WIDTH-1:0]  coeffs,
  input  logic [TRANS_WIDTH-1:0] trans,
  output coord_t                 wmin,
  output coord_t                 wmax
);

  function automatic coord_t round_sat(input logic signed [SUM_WIDTH-1:0] v);
    logic signed [SUM_WIDTH-1:0]  r;
    logic signed [QUOT_WIDTH-1:0] q;
    logic                         fits;
    coord_t                       res;
    r    = v + SUM_WIDTH'(1 << (FRAC_SHIFT - 1));
    q    = QUOT_WIDTH'(r >>> FRAC_SHIFT);
    fits = (&q[QUOT_WIDTH-1:COORD_WIDTH-1]) || !(|q[QUOT_WIDTH-1:COORD_WIDTH-1]);
    if (fits) begin
      res = q[COORD_WIDTH-1:0];
    end else if (q[QUOT_WIDTH-1]) begin
      res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
    return res;
  endfunction

  coord_t                        lo_a [LANES];
  coord_t                        hi_a [LANES];
  logic signed [COEF_WIDTH-1:0]  c    [LANES];
  logic signed [PROD_WIDTH-1:0]  pa   [LANES];
  logic signed [PROD_WIDTH-1:0]  pb   [LANES];
  logic signed [PROD_WIDTH-1:0]  pmin [LANES];
  logic signed [PROD_WIDTH-1:0]  pmax [LANES];
  logic signed [SUM_WIDTH-1:0]   t_ext;
  logic signed [SUM_WIDTH-1:0]   smin;
  logic signed [SUM_WIDTH-1:0]   smax;

  assign lo_a[0] = lo.x;
  assign lo_a[1] = lo.y;
  assign lo_a[2] = lo.z;
  assign hi_a[0] = hi.x;
  assign hi_a[1] = hi.y;
  assign hi_a[2] = hi.z;

  // each term contributes its smaller product to the minimum, larger to the maximum
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      c[j]    = coeffs[j*COEF_WIDTH +: COEF_WIDTH];
      pa[j]   = c[j] * lo_a[j];
      pb[j]   = c[j] * hi_a[j];
      pmin[j] = (pa[j] < pb[j]) ? pa[j] : pb[j];
      pmax[j] = (pa[j] < pb[j]) ? pb[j] : pa[j];
    end
  end

  assign t_ext = SUM_WIDTH'(signed'(trans)) <<< FRAC_SHIFT;

  assign smin = t_ext + SUM_WIDTH'(pmin[0]) + SUM_WIDTH'(pmin[1]) + SUM_WIDTH'(pmin[2]);
  assign smax = t_ext + SUM_WIDTH'(pmax[0]) + SUM_WIDTH'(pmax[1]) + SUM_WIDTH'(pmax[2]);

  assign wmin = round_sat(smin);
  assign wmax = round_sat(smax);

endmodule

>>> src/transformed_aabb_overlap.sv
// ----------------------------------------------------------------------------
// transformed_aabb_overlap: transformed box bounds and box overlap test
// Maps a local box through an affine transform to a world box, stores it as
// the reference or tests it against the stored reference.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one item word per handshake: opcode, local box corners,
//          three packed matrix rows and the packed translation.
//   out_ch carries one result word per item: the saturated world box and the
//          overlap flag (set only for a test whose box touches or overlaps).
//   A word taken at one clock edge sits in the input register; its result is
//   computed in a single pass and lands in the output register once that
//   register is empty or being drained, which raises out_ch.valid. One word
//   is accepted every cycle while out_ch.ready stays high; the eighteen
//   coefficient multiplies of the three axis units run in parallel in one pass.
//   A store updates the reference at the edge its result is registered, so a
//   test word directly behind it already sees the new reference.
//   Reset clears both stages and sets the reference box to all zeros.
//   When out_ch.ready is low the result holds; the input register still
//   takes one more word, then in_ch.ready drops until the output drains.
// ----------------------------------------------------------------------------
module transformed_aabb_overlap import taabb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  taabb_in_if.sink    in_ch,
  taabb_out_if.source out_ch
);

  logic      s1_valid_r, s1_valid_nxt;
  in_word_t  s1_r;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_r, out_nxt;
  box_t      ref_r, ref_nxt;

  logic      advance;
  logic      take;
  vec3_t     lo, hi;
  vec3_t     wmin, wmax;
  logic      hit;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  assign lo.x = s1_r.local_min_x;
  assign lo.y = s1_r.local_min_y;
  assign lo.z = s1_r.local_min_z;
  assign hi.x = s1_r.local_max_x;
  assign hi.y = s1_r.local_max_y;
  assign hi.z = s1_r.local_max_z;

  taabb_axis u_axis_x (
    .lo     (lo),
    .hi     (hi),
    .coeffs (s1_r.row_x_coeffs),
    .trans  (s1_r.translation[0*TRANS_WIDTH +: TRANS_WIDTH]),
    .wmin   (wmin.x),
    .wmax   (wmax.x)
  );

  taabb_axis u_axis_y (
    .lo     (lo),
    .hi     (hi),
    .coeffs (s1_r.row_y_coeffs),
    .trans  (s1_r.translation[1*TRANS_WIDTH +: TRANS_WIDTH]),
    .wmin   (wmin.y),
    .wmax   (wmax.y)
  );

  taabb_axis u_axis_z (
    .lo     (lo),
    .hi     (hi),
    .coeffs (s1_r.row_z_coeffs),
    .trans  (s1_r.translation[2*TRANS_WIDTH +: TRANS_WIDTH]),
    .wmin   (wmin.z),
    .wmax   (wmax.z)
  );

  // touching counts as overlap; an inverted reference is taken literally
  assign hit = !(wmin.x > ref_r.hi.x || wmax.x < ref_r.lo.x)
            && !(wmin.y > ref_r.hi.y || wmax.y < ref_r.lo.y)
            && !(wmin.z > ref_r.hi.z || wmax.z < ref_r.lo.z);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    out_nxt.world_min_x = wmin.x;
    out_nxt.world_min_y = wmin.y;
    out_nxt.world_min_z = wmin.z;
    out_nxt.world_max_x = wmax.x;
    out_nxt.world_max_y = wmax.y;
    out_nxt.world_max_z = wmax.z;
    out_nxt.overlap     = (s1_r.opcode == OP_TEST) && hit;

    ref_nxt = ref_r;
    if (advance && s1_r.opcode == OP_STORE) begin
      ref_nxt.lo = wmin;
      ref_nxt.hi = wmax;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ref_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      ref_r       <= ref_nxt;
    end
  end

  // payload: hold unless a word moves in
  always_ff @(posedge clk) begin
    if (take) begin
      s1_r <= in_ch.data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

endmodule
